@@ src/lkv_pkg.sv @@
// shared types and constants for the lru key/value cache
// no dependencies; used by lkv_lane and lru_key_value_cache_unit
package lkv_pkg;

    localparam int unsigned LKV_ENTRIES_DEF = 64;
    localparam int unsigned KEY_W           = 32;
    localparam int unsigned VAL_W           = 32;

    typedef enum logic [0:0] {
        OP_GET = 1'b0,
        OP_SET = 1'b1
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] write_value;
    } t_req;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } t_rsp;

    // per-access update control broadcast to every lane
    typedef struct packed {
        logic update;     // state changes this cycle
        logic age_all;    // fill: every valid lane ages
        logic write_key;  // selected lane takes the new key
        logic write_val;  // selected lane takes the new value
    } t_lane_ctrl;

endpackage

@@ src/lru_key_value_cache_unit.sv @@
// lru key/value cache: request register, lane array and result register
// depends on lkv_pkg and lkv_lane
//
// request register, then lane lookup/update and result register in one pass
// throughput: one beat per cycle unless the output stalls; the lane array is
//   read and updated at the same edge, so back-to-back accesses see each
//   other's effects
// reset (synchronous, active low) clears valid marks, age ranks, occupancy
//   and both handshake stages; keys and values are not cleared
module lru_key_value_cache_unit
    import lkv_pkg::*;
#(
    parameter int unsigned ENTRIES = LKV_ENTRIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data
);

    localparam int unsigned RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned OCC_W  = $clog2(ENTRIES + 1);
    localparam logic [RANK_W-1:0] RANK_OLDEST = RANK_W'(ENTRIES - 1);
    localparam logic [OCC_W-1:0]  OCC_FULL    = OCC_W'(ENTRIES);

    // request register
    logic r_in_valid;
    t_req r_in;

    // result register
    logic r_out_valid;
    t_rsp r_out;
    t_rsp n_out;

    // occupancy count
    logic [OCC_W-1:0] r_occ;

    logic advance;

    // per-lane views
    logic [ENTRIES-1:0] lane_match;
    logic [ENTRIES-1:0] lane_valid;
    logic [ENTRIES-1:0] lane_oldest;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] first_free;
    logic [ENTRIES-1:0] sel_vec;
    logic [RANK_W-1:0]  lane_rank  [ENTRIES];
    logic [KEY_W-1:0]   lane_key   [ENTRIES];
    logic [VAL_W-1:0]   lane_value [ENTRIES];

    logic              hit_any;
    logic              full;
    logic              is_set;
    logic [RANK_W-1:0] hit_rank;
    logic [VAL_W-1:0]  hit_value;
    logic [KEY_W-1:0]  victim_key;
    logic [RANK_W-1:0] sel_rank;
    t_lane_ctrl        ctrl;

    // the pass advances when the result register is free or being drained
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // lane array
    for (genvar g = 0; g < ENTRIES; g++) begin : g_lane
        lkv_lane #(
            .RANK_W (RANK_W)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_sel      (sel_vec[g]),
            .i_sel_rank (sel_rank),
            .i_key      (r_in.key),
            .i_value    (r_in.write_value),
            .o_match    (lane_match[g]),
            .o_valid    (lane_valid[g]),
            .o_rank     (lane_rank[g]),
            .o_key      (lane_key[g]),
            .o_value    (lane_value[g])
        );
        // when full the ranks are 0..ENTRIES-1, so exactly one lane is oldest
        assign lane_oldest[g] = lane_valid[g] && (lane_rank[g] == RANK_OLDEST);
    end

    // lowest-numbered free slot as a one-hot vector
    assign free_vec   = ~lane_valid;
    assign first_free = free_vec & (~free_vec + ENTRIES'(1));

    assign hit_any = |lane_match;
    assign full    = (r_occ == OCC_FULL);
    assign is_set  = (r_in.op == OP_SET);

    // one-hot and-or reductions: keys are unique among valid lanes
    always_comb begin
        hit_rank   = '0;
        hit_value  = '0;
        victim_key = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_rank   = hit_rank   | (lane_match[i]  ? lane_rank[i]  : '0);
            hit_value  = hit_value  | (lane_match[i]  ? lane_value[i] : '0);
            victim_key = victim_key | (lane_oldest[i] ? lane_key[i]   : '0);
        end
    end

    // slot selection: hit slot, else free slot while filling, else lru victim
    always_comb begin
        if (hit_any) begin
            sel_vec  = lane_match;
            sel_rank = hit_rank;
        end else if (full) begin
            sel_vec  = lane_oldest;
            sel_rank = RANK_OLDEST;
        end else begin
            sel_vec  = first_free;
            sel_rank = RANK_OLDEST;
        end
    end

    // a get miss leaves the state untouched
    always_comb begin
        ctrl.update    = advance && (hit_any || is_set);
        ctrl.age_all   = !hit_any && !full;
        ctrl.write_key = !hit_any;
        ctrl.write_val = is_set;
    end

    always_comb begin
        n_out.hit         = hit_any;
        n_out.read_value  = (hit_any && !is_set) ? hit_value : '0;
        n_out.evicted     = !hit_any && is_set && full;
        n_out.evicted_key = (!hit_any && is_set && full) ? victim_key : '0;
    end

    // occupancy only grows on a set miss into a free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (ctrl.update && !hit_any && !full) begin
            r_occ <= r_occ + OCC_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

@@ src/lkv_lane.sv @@
// one cache slot: key, value, valid mark and age rank with its own compare
// depends on lkv_pkg
module lkv_lane
    import lkv_pkg::*;
#(
    parameter int unsigned RANK_W = $clog2(LKV_ENTRIES_DEF)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_lane_ctrl        i_ctrl,
    input  logic              i_sel,
    input  logic [RANK_W-1:0] i_sel_rank,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [VAL_W-1:0]  i_value,
    output logic              o_match,
    output logic              o_valid,
    output logic [RANK_W-1:0] o_rank,
    output logic [KEY_W-1:0]  o_key,
    output logic [VAL_W-1:0]  o_value
);

    logic              r_valid;
    logic [RANK_W-1:0] r_rank;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_value;
    logic              ages;

    assign o_match = r_valid && (r_key == i_key);
    assign o_valid = r_valid;
    assign o_rank  = r_rank;
    assign o_key   = r_key;
    assign o_value = r_value;

    // younger than the promoted slot, or every slot on a fill
    assign ages = r_valid && !i_sel && (i_ctrl.age_all || (r_rank < i_sel_rank));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_ctrl.update) begin
            if (i_sel) begin
                r_valid <= 1'b1;
                r_rank  <= '0;
            end else if (ages) begin
                r_rank  <= r_rank + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.update && i_sel && i_ctrl.write_key) begin
            r_key <= i_key;
        end
        if (i_ctrl.update && i_sel && i_ctrl.write_val) begin
            r_value <= i_value;
        end
    end

endmodule
